>>> rtl/mdst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdst_pkg
// Shared types and constants for the multi-drive step tone generator.
// ----------------------------------------------------------------------------
package mdst_pkg;

    localparam int MAX_DRIVES = 16;
    localparam int PERIOD_W   = 16;
    localparam int POS_W      = 8;
    localparam int DRIVE_W    = 5;
    localparam int CFG_IDX_W  = 2;

    localparam logic [POS_W-1:0] FULL_MAX_RST   = 8'd158;
    localparam logic [POS_W-1:0] NARROW_MIN_RST = 8'd79;
    localparam logic [POS_W-1:0] NARROW_MAX_RST = 8'd81;

    typedef enum logic [2:0] {
        ACT_TICK       = 3'd0,
        ACT_SET_PERIOD = 3'd1,
        ACT_SET_MOVE   = 3'd2,
        ACT_RESET      = 3'd3,
        ACT_HALT       = 3'd4
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL_MAX   = 2'd0,
        CFG_NARROW_MIN = 2'd1,
        CFG_NARROW_MAX = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [POS_W-1:0] full_max;
        logic [POS_W-1:0] narrow_min;
        logic [POS_W-1:0] narrow_max;
    } t_bounds;

    typedef struct packed {
        logic                tick;
        logic                set_period;
        logic                set_move;
        logic                clr;
        logic                halt;
        logic [PERIOD_W-1:0] period;
        logic                move_full;
    } t_lane_cmd;

endpackage

>>> rtl/mdst_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdst_lane
// One drive: half-period counter, head position, direction and step level.
// ----------------------------------------------------------------------------
module mdst_lane
    import mdst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lane_cmd i_cmd,
    input  t_bounds   i_bounds,
    input  logic      i_step_bit,
    input  logic      i_dir_bit,
    output logic      o_step_bit,
    output logic      o_dir_bit
);

    logic [PERIOD_W-1:0] r_hp, n_hp;
    logic [PERIOD_W-1:0] r_cnt, n_cnt;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic                r_rev, n_rev;
    logic                r_lvl, n_lvl;
    logic                r_narrow, n_narrow;

    logic [PERIOD_W:0]   cnt_inc;
    logic                active;
    logic                hit;
    logic [POS_W-1:0]    lo_bound;
    logic [POS_W-1:0]    hi_bound;
    logic                rev_step;

    assign active   = i_cmd.tick && (r_hp != '0);
    assign cnt_inc  = {1'b0, r_cnt} + {{PERIOD_W{1'b0}}, 1'b1};
    assign hit      = cnt_inc >= {1'b0, r_hp};
    assign lo_bound = r_narrow ? i_bounds.narrow_min : '0;
    assign hi_bound = r_narrow ? i_bounds.narrow_max : i_bounds.full_max;

    always_comb begin
        if (r_pos >= hi_bound) begin
            rev_step = 1'b1;
        end else if (r_pos <= lo_bound) begin
            rev_step = 1'b0;
        end else begin
            rev_step = r_rev;
        end
    end

    always_comb begin
        n_hp       = r_hp;
        n_cnt      = r_cnt;
        n_pos      = r_pos;
        n_rev      = r_rev;
        n_lvl      = r_lvl;
        n_narrow   = r_narrow;
        o_step_bit = i_step_bit;
        o_dir_bit  = i_dir_bit;
        if (active) begin
            if (hit) begin
                n_cnt      = '0;
                n_rev      = rev_step;
                n_pos      = rev_step ? r_pos - 1'b1 : r_pos + 1'b1;
                n_lvl      = ~r_lvl;
                o_step_bit = r_lvl;
                o_dir_bit  = rev_step;
            end else begin
                n_cnt = cnt_inc[PERIOD_W-1:0];
            end
        end
        if (i_cmd.set_period) begin
            n_hp = i_cmd.period;
        end
        if (i_cmd.set_move) begin
            n_narrow = ~i_cmd.move_full;
        end
        if (i_cmd.clr) begin
            n_hp       = '0;
            n_pos      = '0;
            n_rev      = 1'b0;
            n_lvl      = 1'b0;
            n_narrow   = 1'b0;
            o_step_bit = 1'b0;
            o_dir_bit  = 1'b0;
        end
        if (i_cmd.halt) begin
            n_hp = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp     <= '0;
            r_cnt    <= '0;
            r_pos    <= '0;
            r_rev    <= 1'b0;
            r_lvl    <= 1'b0;
            r_narrow <= 1'b0;
        end else begin
            r_hp     <= n_hp;
            r_cnt    <= n_cnt;
            r_pos    <= n_pos;
            r_rev    <= n_rev;
            r_lvl    <= n_lvl;
            r_narrow <= n_narrow;
        end
    end

    a_silenced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.halt || i_cmd.clr) |=> (r_hp == '0))
        else $error("drive not silenced after halt or reset");

    a_clr_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr |=> (r_pos == '0) && !r_rev && !r_lvl && !r_narrow)
        else $error("drive state not cleared after reset");

    a_step_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (active && hit) |=> (r_cnt == '0) && (r_lvl != $past(r_lvl)))
        else $error("step did not clear count and toggle level");

endmodule

>>> rtl/multi_drive_step_tone_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_drive_step_tone_generator_top
// Multi-drive stepper tone generator: command register, drive lanes and
// step/direction line result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one command per transfer:
//   tick, set period, set movement, reset drive(s) or halt all.
//   Output channel (o_valid / i_stall) returns one transfer per command,
//   the step and direction line vectors after that command took effect.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the position bounds;
//   it is always ready; the user must write it only while the block is idle,
//   which the block itself does not enforce. Throughput: one command per
//   cycle while the receiver does not stall; a command is applied to the
//   drive lanes it addresses in the cycle it moves from the command register
//   into the result register. If the receiver stalls, the result register
//   holds, the command register holds one more command, then o_stall rises.
//   Reset (synchronous, active low) silences all drives, clears positions,
//   directions, step levels and line outputs, and restores default bounds.
// ----------------------------------------------------------------------------
module multi_drive_step_tone_generator_top
    import mdst_pkg::*;
#(
    parameter int NUM_DRIVES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [2:0]           i_action,
    input  logic [DRIVE_W-1:0]   i_drive,
    input  logic [PERIOD_W-1:0]  i_period,
    input  logic                 i_movement_full,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [MAX_DRIVES-1:0] o_step_lines,
    output logic [MAX_DRIVES-1:0] o_dir_lines,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [POS_W-1:0]     i_cfg_data
);

    logic                  r_in_valid;
    logic [2:0]            r_action;
    logic [DRIVE_W-1:0]    r_drive;
    logic [PERIOD_W-1:0]   r_period;
    logic                  r_move_full;
    logic                  r_out_valid;
    logic [MAX_DRIVES-1:0] r_step_lines, n_step_lines;
    logic [MAX_DRIVES-1:0] r_dir_lines, n_dir_lines;
    t_bounds               r_bounds;
    logic                  adv;
    logic                  in_xfer;

    assign adv         = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall     = r_in_valid && !adv;
    assign in_xfer     = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_action    <= i_action;
            r_drive     <= i_drive;
            r_period    <= i_period;
            r_move_full <= i_movement_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds <= '{full_max: FULL_MAX_RST, narrow_min: NARROW_MIN_RST,
                          narrow_max: NARROW_MAX_RST};
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FULL_MAX:   r_bounds.full_max   <= i_cfg_data;
                CFG_NARROW_MIN: r_bounds.narrow_min <= i_cfg_data;
                CFG_NARROW_MAX: r_bounds.narrow_max <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_DRIVES; gi++) begin : g_lane
            if (gi < NUM_DRIVES) begin : g_used
                localparam logic [DRIVE_W-1:0] DRV_NUM = DRIVE_W'(gi + 1);
                t_lane_cmd cmd;
                logic      sel;

                assign sel = adv && (r_drive == DRV_NUM);
                assign cmd = '{
                    tick:       adv && (r_action == ACT_TICK),
                    set_period: sel && (r_action == ACT_SET_PERIOD),
                    set_move:   sel && (r_action == ACT_SET_MOVE),
                    clr:        adv && (r_action == ACT_RESET) &&
                                ((r_drive == '0) || (r_drive == DRV_NUM)),
                    halt:       adv && (r_action == ACT_HALT),
                    period:     r_period,
                    move_full:  r_move_full
                };

                mdst_lane u_lane (
                    .i_clk      (i_clk),
                    .i_rst_n    (i_rst_n),
                    .i_cmd      (cmd),
                    .i_bounds   (r_bounds),
                    .i_step_bit (r_step_lines[gi]),
                    .i_dir_bit  (r_dir_lines[gi]),
                    .o_step_bit (n_step_lines[gi]),
                    .o_dir_bit  (n_dir_lines[gi])
                );
            end else begin : g_unused
                assign n_step_lines[gi] = 1'b0;
                assign n_dir_lines[gi]  = 1'b0;
            end
        end
    endgenerate

    // Result register doubles as the line state: it loads exactly when a
    // command is applied.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_step_lines <= '0;
            r_dir_lines  <= '0;
        end else begin
            if (adv) begin
                r_out_valid  <= 1'b1;
                r_step_lines <= n_step_lines;
                r_dir_lines  <= n_dir_lines;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_step_lines = r_step_lines;
    assign o_dir_lines  = r_dir_lines;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid && i_stall)
        else $error("input stalled without a blocked result");

    a_lines_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_step_lines) && $stable(r_dir_lines))
        else $error("line state changed without a command");

    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("applied command produced no result");

endmodule
